>>> sv/headset_hook_key_detector_defines.svh
// assertion macros used by the headset hook key detector core
`ifndef HEADSET_HOOK_KEY_DETECTOR_DEFINES_SVH
`define HEADSET_HOOK_KEY_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define HHKD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hhkd: same-cycle check failed");

// next-cycle implication, checked out of reset
`define HHKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hhkd: next-cycle check failed");

`else

`define HHKD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HHKD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/hhkd_pkg.sv
// types, codes and reset values of the headset hook key detector
`default_nettype none

package hhkd_pkg;

	// command codes of an input item
	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_SW_ENABLE  = 3'd1,
		CMD_SW_DISABLE = 3'd2,
		CMD_MIC_ON     = 3'd3,
		CMD_MIC_OFF    = 3'd4
	} cmd_t;

	// key event codes of a result item
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} ev_t;

	// detector phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_PROBE   = 4'b0010,
		PH_MONITOR = 4'b0100,
		PH_CONFIRM = 4'b1000
	} phase_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SETTLE   = 3'd0,
		REG_POLL     = 3'd1,
		REG_RETRY    = 3'd2,
		REG_ATTEMPTS = 3'd3,
		REG_SAMPLES  = 3'd4,
		REG_RELEASE  = 3'd5
	} reg_idx_t;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// register reset values
	localparam logic [9:0]  SETTLE_RST   = 10'd25;
	localparam logic [9:0]  POLL_RST     = 10'd40;
	localparam logic [11:0] RETRY_RST    = 12'd1000;
	localparam logic [2:0]  ATTEMPTS_RST = 3'd3;
	localparam logic [2:0]  SAMPLES_RST  = 3'd3;
	localparam logic [3:0]  RELEASE_RST  = 4'd5;

	typedef struct packed {
		logic [2:0] cmd;
		logic       pin_level;
	} in_item_t;

	typedef struct packed {
		logic       key_pressed;
		logic [1:0] key_event;
		logic       mic_bias_on;
		logic       pull_up;
		logic       detector_active;
	} out_item_t;

	typedef struct packed {
		logic [9:0]  settle_ticks;
		logic [9:0]  poll_ticks;
		logic [11:0] retry_ticks;
		logic [2:0]  probe_attempts;
		logic [2:0]  probe_samples;
		logic [3:0]  release_samples;
	} cfg_t;

	// an interval of n ticks loads n-1; zero behaves like one
	function automatic logic [11:0] load_ticks(input logic [11:0] v);
		return (v == 12'd0) ? 12'd0 : v - 12'd1;
	endfunction

endpackage

`default_nettype wire

>>> sv/hhkd_cfg.sv
// apb register file holding the detector timing and count settings
`default_nettype none

module hhkd_cfg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          wr_en,
	input  wire  [hhkd_pkg::ADDR_W-1:0]  paddr,
	input  wire  [hhkd_pkg::DATA_W-1:0]  pwdata,
	output logic [hhkd_pkg::DATA_W-1:0]  prdata,
	output hhkd_pkg::cfg_t               cfg
);
	import hhkd_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;

	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks    <= SETTLE_RST;
			cfg_q.poll_ticks      <= POLL_RST;
			cfg_q.retry_ticks     <= RETRY_RST;
			cfg_q.probe_attempts  <= ATTEMPTS_RST;
			cfg_q.probe_samples   <= SAMPLES_RST;
			cfg_q.release_samples <= RELEASE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SETTLE:   cfg_q.settle_ticks    <= pwdata[9:0];
				REG_POLL:     cfg_q.poll_ticks      <= pwdata[9:0];
				REG_RETRY:    cfg_q.retry_ticks     <= pwdata[11:0];
				REG_ATTEMPTS: cfg_q.probe_attempts  <= pwdata[2:0];
				REG_SAMPLES:  cfg_q.probe_samples   <= pwdata[2:0];
				REG_RELEASE:  cfg_q.release_samples <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_SETTLE:   prdata = {22'd0, cfg_q.settle_ticks};
			REG_POLL:     prdata = {22'd0, cfg_q.poll_ticks};
			REG_RETRY:    prdata = {20'd0, cfg_q.retry_ticks};
			REG_ATTEMPTS: prdata = {29'd0, cfg_q.probe_attempts};
			REG_SAMPLES:  prdata = {29'd0, cfg_q.probe_samples};
			REG_RELEASE:  prdata = {28'd0, cfg_q.release_samples};
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/hhkd_core.sv
// detector state machine: next-state logic, state registers and result fields
`default_nettype none
`include "headset_hook_key_detector_defines.svh"

module hhkd_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step_en,
	input  hhkd_pkg::in_item_t    item,
	input  hhkd_pkg::cfg_t        cfg,
	output hhkd_pkg::out_item_t   result
);
	import hhkd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [2:0]  attempt_q, attempt_n;
	logic [3:0]  sample_q, sample_n;
	logic [11:0] wait_q, wait_n;
	logic        last_q, last_n;
	logic        key_down_q, key_down_n;
	logic        switch_q, switch_n;
	logic        transmit_q, transmit_n;
	logic        mic_q, mic_n;
	logic        pull_up_q, pull_up_n;
	ev_t         ev;

	logic [3:0]  attempt_inc;
	logic [4:0]  sample_inc;
	logic [11:0] poll_load;

	assign attempt_inc = {1'b0, attempt_q} + 4'd1;
	assign sample_inc  = {1'b0, sample_q} + 5'd1;
	assign poll_load   = load_ticks({2'd0, cfg.poll_ticks});

	// next state for one item
	always_comb begin
		phase_n    = phase_q;
		attempt_n  = attempt_q;
		sample_n   = sample_q;
		wait_n     = wait_q;
		last_n     = last_q;
		key_down_n = key_down_q;
		switch_n   = switch_q;
		transmit_n = transmit_q;
		mic_n      = mic_q;
		pull_up_n  = pull_up_q;
		ev         = EV_NONE;
		case (item.cmd)
			CMD_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (wait_q != 12'd0) begin
						wait_n = wait_q - 12'd1;
					end else begin
						case (phase_q)
							PH_PROBE: begin
								if (item.pin_level) begin
									attempt_n = attempt_inc[2:0];
									sample_n  = 4'd0;
									if (attempt_inc >= {1'b0, cfg.probe_attempts}) begin
										phase_n = PH_IDLE;
									end else begin
										wait_n = load_ticks(cfg.retry_ticks);
									end
								end else if (sample_inc >= {2'd0, cfg.probe_samples}) begin
									phase_n  = PH_MONITOR;
									sample_n = 4'd0;
									last_n   = 1'b0;
									wait_n   = poll_load;
								end else begin
									sample_n = sample_inc[3:0];
									wait_n   = load_ticks({2'd0, cfg.settle_ticks});
								end
							end
							PH_MONITOR: begin
								if (item.pin_level != last_q) begin
									if (!item.pin_level && key_down_q) begin
										phase_n  = PH_CONFIRM;
										sample_n = 4'd0;
									end else if (item.pin_level && !key_down_q) begin
										key_down_n = 1'b1;
										ev         = EV_PRESS;
									end
								end
								last_n = item.pin_level;
								wait_n = poll_load;
							end
							PH_CONFIRM: begin
								last_n = item.pin_level;
								if (item.pin_level) begin
									phase_n = PH_MONITOR;
								end else begin
									sample_n = sample_inc[3:0];
									if (sample_inc >= {1'b0, cfg.release_samples}) begin
										if (key_down_q) begin
											key_down_n = 1'b0;
											ev         = EV_RELEASE;
										end
										phase_n = PH_MONITOR;
									end
								end
								wait_n = poll_load;
							end
							default: ;
						endcase
					end
				end
			end
			CMD_SW_ENABLE: begin
				if (!switch_q) begin
					if (key_down_q) begin
						key_down_n = 1'b0;
						ev         = EV_RELEASE;
					end
					switch_n  = 1'b1;
					mic_n     = 1'b1;
					pull_up_n = 1'b1;
					phase_n   = PH_PROBE;
					attempt_n = 3'd0;
					sample_n  = 4'd0;
					wait_n    = 12'd0;
					last_n    = 1'b0;
				end
			end
			CMD_SW_DISABLE: begin
				if (switch_q) begin
					if (key_down_q) begin
						key_down_n = 1'b0;
						ev         = EV_RELEASE;
					end
					switch_n  = 1'b0;
					mic_n     = transmit_q;
					pull_up_n = 1'b0;
					phase_n   = PH_IDLE;
					attempt_n = 3'd0;
					sample_n  = 4'd0;
					wait_n    = 12'd0;
				end
			end
			CMD_MIC_ON: begin
				transmit_n = 1'b1;
				mic_n      = 1'b1;
			end
			CMD_MIC_OFF: begin
				transmit_n = 1'b0;
				mic_n      = switch_q;
			end
			default: ;
		endcase
	end

	// result fields reflect the state after the item
	assign result.key_pressed     = key_down_n;
	assign result.key_event       = ev;
	assign result.mic_bias_on     = mic_n;
	assign result.pull_up         = pull_up_n;
	assign result.detector_active = (phase_n != PH_IDLE);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			attempt_q  <= 3'd0;
			sample_q   <= 4'd0;
			wait_q     <= 12'd0;
			last_q     <= 1'b0;
			key_down_q <= 1'b0;
			switch_q   <= 1'b0;
			transmit_q <= 1'b0;
			mic_q      <= 1'b0;
			pull_up_q  <= 1'b0;
		end else if (step_en) begin
			phase_q    <= phase_n;
			attempt_q  <= attempt_n;
			sample_q   <= sample_n;
			wait_q     <= wait_n;
			last_q     <= last_n;
			key_down_q <= key_down_n;
			switch_q   <= switch_n;
			transmit_q <= transmit_n;
			mic_q      <= mic_n;
			pull_up_q  <= pull_up_n;
		end
	end

	// consistency checks
	`HHKD_ASSERT_IMPL(a_pull_follows_switch, clk, arst_n, 1'b1, pull_up_q == switch_q)
	`HHKD_ASSERT_IMPL(a_mic_is_or, clk, arst_n, 1'b1, mic_q == (switch_q | transmit_q))
	`HHKD_ASSERT_IMPL(a_active_needs_switch, clk, arst_n, phase_q != PH_IDLE, switch_q)
	`HHKD_ASSERT_IMPL(a_confirm_needs_key, clk, arst_n, phase_q == PH_CONFIRM, key_down_q)
	`HHKD_ASSERT_NEXT(a_press_sets_key, clk, arst_n, step_en && (ev == EV_PRESS), key_down_q)

endmodule

`default_nettype wire

>>> sv/headset_hook_key_detector.sv
// top level of the headset hook key detector
//
// Usage:
//   Each command item (tick with pin level, switch enable or disable, mic on
//   or off) enters on the cmd channel and gives exactly one result item on
//   the rsp channel: key state, key event, mic bias, pull direction and
//   detector activity after that command.
//   An item is taken into an input register, worked on by the state machine
//   and written with the new state into the result register, from which it
//   is presented on rsp. One item per cycle is sustained while rsp_stall is
//   low: the only loop is the state update of the detector state machine.
//   When rsp_stall is high and the result register is full, that register
//   holds and the input register keeps its item; cmd_stall rises only when
//   both are full and rsp stalls. Reset clears all detector state, empties
//   both registers and loads the register defaults (settle 25, poll 40,
//   retry 1000, attempts 3, probe samples 3, release samples 5). Registers
//   are written over the apb port, one register per word. The user must
//   write them only while no item is in flight; the block does not enforce
//   this.
`default_nettype none

module headset_hook_key_detector (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cmd_valid,
	output logic                         cmd_stall,
	input  hhkd_pkg::in_item_t           cmd_item,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output hhkd_pkg::out_item_t          rsp_item,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [hhkd_pkg::ADDR_W-1:0]  paddr,
	input  wire  [hhkd_pkg::DATA_W-1:0]  pwdata,
	output logic [hhkd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import hhkd_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t rsp_item_s2;
	logic      rsp_valid_s2;
	logic      advance;
	logic      step_en;
	logic      cmd_accept;

	// handshake control
	assign advance    = !rsp_valid_s2 || !rsp_stall;
	assign step_en    = valid_s1 && advance;
	assign cmd_stall  = valid_s1 && !advance;
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign rsp_valid  = rsp_valid_s2;
	assign rsp_item   = rsp_item_s2;
	assign pready     = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			item_s1 <= cmd_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= step_en;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			rsp_item_s2 <= result;
		end
	end

	hhkd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (psel && penable && pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	hhkd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the headset hook key detector
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hhkd_pkg::*;

	// command codes the block does not define
	localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
	localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

	// register slots past the last defined one
	localparam int SPARE_REG_A = 6;
	localparam int SPARE_REG_B = 7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cmd_valid = 1'b0;
	logic cmd_stall;
	in_item_t cmd_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	out_item_t rsp_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	headset_hook_key_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// item queues and bookkeeping
	in_item_t cmd_backlog[$];
	out_item_t predicted_rsp[$];
	bit cmd_took = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int queued = 0;
	int items_taken = 0;
	int rsp_seen = 0;
	int presses = 0;
	int releases = 0;
	int settings_run = 0;

	// shadow of the block's registers and detector state
	cfg_t cfg;
	phase_t ph;
	logic [2:0] attempts_done;
	logic [3:0] samples;
	logic [11:0] wait_cnt;
	logic last_lvl, key_down, sw_req, tx_req, pull_on;

	// n ticks between samples means the counter is loaded with n-1, zero acts as one
	function automatic logic [11:0] span_to_wait(logic [11:0] n);
		return n - (n != 12'd0);
	endfunction

	function automatic ev_t drop_key();
		if (key_down) begin
			key_down = 1'b0;
			return EV_RELEASE;
		end
		return EV_NONE;
	endfunction

	// advance the shadow detector by one item and build its result
	function automatic out_item_t detector_next(in_item_t it);
		ev_t ev;
		out_item_t r;
		logic lvl;
		ev = EV_NONE;
		lvl = it.pin_level;
		case (it.cmd)
			CMD_TICK: begin
				if (ph != PH_IDLE) begin
					if (wait_cnt != 12'd0) begin
						wait_cnt = wait_cnt - 12'd1;
					end else if (ph == PH_PROBE) begin
						if (lvl) begin
							attempts_done = attempts_done + 3'd1;
							samples = '0;
							if (attempts_done >= cfg.probe_attempts)
								ph = PH_IDLE;
							else
								wait_cnt = span_to_wait(cfg.retry_ticks);
						end else begin
							samples = samples + 4'd1;
							if (samples >= cfg.probe_samples) begin
								ph = PH_MONITOR;
								samples = '0;
								last_lvl = 1'b0;
								wait_cnt = span_to_wait({2'd0, cfg.poll_ticks});
							end else begin
								wait_cnt = span_to_wait({2'd0, cfg.settle_ticks});
							end
						end
					end else if (ph == PH_MONITOR) begin
						if (lvl != last_lvl) begin
							if (!lvl && key_down) begin
								ph = PH_CONFIRM;
								samples = '0;
							end else if (lvl && !key_down) begin
								key_down = 1'b1;
								ev = EV_PRESS;
							end
						end
						last_lvl = lvl;
						wait_cnt = span_to_wait({2'd0, cfg.poll_ticks});
					end else begin
						// release confirmation: a high poll aborts it
						last_lvl = lvl;
						if (lvl) begin
							ph = PH_MONITOR;
						end else begin
							samples = samples + 4'd1;
							if (samples >= cfg.release_samples) begin
								ev = drop_key();
								ph = PH_MONITOR;
							end
						end
						wait_cnt = span_to_wait({2'd0, cfg.poll_ticks});
					end
				end
			end
			CMD_SW_ENABLE: begin
				if (!sw_req) begin
					ev = drop_key();
					sw_req = 1'b1;
					pull_on = 1'b1;
					ph = PH_PROBE;
					attempts_done = '0;
					samples = '0;
					wait_cnt = '0;
					last_lvl = 1'b0;
				end
			end
			CMD_SW_DISABLE: begin
				if (sw_req) begin
					ev = drop_key();
					sw_req = 1'b0;
					pull_on = 1'b0;
					ph = PH_IDLE;
					attempts_done = '0;
					samples = '0;
					wait_cnt = '0;
				end
			end
			CMD_MIC_ON: tx_req = 1'b1;
			CMD_MIC_OFF: tx_req = 1'b0;
			default: ;
		endcase
		r.key_pressed = key_down;
		r.key_event = ev;
		r.mic_bias_on = sw_req | tx_req;
		r.pull_up = pull_on;
		r.detector_active = (ph != PH_IDLE);
		return r;
	endfunction

	// driver: new inputs at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd_valid || cmd_took) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_item <= cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: predict on each accepted item, check each accepted result
	always @(posedge clk) begin
		out_item_t want;
		cmd_took = 1'b0;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				cmd_took = 1'b1;
				want = detector_next(cmd_item);
				if (want.key_event == EV_PRESS)
					presses++;
				if (want.key_event == EV_RELEASE)
					releases++;
				predicted_rsp.push_back(want);
				items_taken++;
			end
			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (predicted_rsp.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result %0d arrived with no item outstanding", rsp_seen);
				end else begin
					want = predicted_rsp.pop_front();
					if (rsp_item !== want) begin
						errors++;
						if (errors <= 10)
							$display({"result %0d: expected key=%0d ev=%0d mic=%0d pull=%0d act=%0d,",
								" got key=%0d ev=%0d mic=%0d pull=%0d act=%0d"}, rsp_seen,
								want.key_pressed, want.key_event, want.mic_bias_on,
								want.pull_up, want.detector_active,
								rsp_item.key_pressed, rsp_item.key_event,
								rsp_item.mic_bias_on, rsp_item.pull_up,
								rsp_item.detector_active);
					end
				end
			end
		end
	end

	// one apb transfer: setup cycle, then access until pready
	task automatic apb_xfer(input bit wr, input int idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic cfg_write(input int idx, input logic [31:0] v);
		logic [31:0] unused;
		apb_xfer(1'b1, idx, v, unused);
		case (idx)
			REG_SETTLE: cfg.settle_ticks = v[9:0];
			REG_POLL: cfg.poll_ticks = v[9:0];
			REG_RETRY: cfg.retry_ticks = v[11:0];
			REG_ATTEMPTS: cfg.probe_attempts = v[2:0];
			REG_SAMPLES: cfg.probe_samples = v[2:0];
			REG_RELEASE: cfg.release_samples = v[3:0];
			default: ;
		endcase
	endtask

	// read every register back against the shadow copy
	task automatic cfg_check();
		logic [31:0] got, want;
		int i;
		for (i = REG_SETTLE; i <= REG_RELEASE; i++) begin
			apb_xfer(1'b0, i, '0, got);
			case (i)
				REG_SETTLE: want = 32'(cfg.settle_ticks);
				REG_POLL: want = 32'(cfg.poll_ticks);
				REG_RETRY: want = 32'(cfg.retry_ticks);
				REG_ATTEMPTS: want = 32'(cfg.probe_attempts);
				REG_SAMPLES: want = 32'(cfg.probe_samples);
				default: want = 32'(cfg.release_samples);
			endcase
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("register %0d reads %0h, expected %0h", i, got, want);
			end
		end
	endtask

	task automatic apply_settings(input int s, input int p, input int r, input int a,
			input int ps, input int rl);
		cfg_write(REG_SETTLE, s);
		cfg_write(REG_POLL, p);
		cfg_write(REG_RETRY, r);
		cfg_write(REG_ATTEMPTS, a);
		cfg_write(REG_SAMPLES, ps);
		cfg_write(REG_RELEASE, rl);
		cfg_check();
		settings_run++;
	endtask

	task automatic queue_item(input logic [2:0] c, input logic lvl);
		in_item_t it;
		it.cmd = c;
		it.pin_level = lvl;
		cmd_backlog.push_back(it);
		queued++;
	endtask

	// one switch session: enable, low lead-in for probing, then random key activity
	task automatic queue_session(input int n_ticks);
		int lead, span, run, i, r;
		bit lvl;
		span = int'(cfg.poll_ticks) * (int'(cfg.release_samples) + 2) + 2;
		if (span > 40)
			span = 40;
		lead = int'(cfg.settle_ticks) * (int'(cfg.probe_samples) + 1) + 2;
		if (lead > 60)
			lead = 60;
		if ($urandom_range(5) == 0)
			queue_item(CMD_TICK, 1'($urandom_range(1)));
		queue_item(CMD_SW_ENABLE, 1'($urandom_range(1)));
		// a few sessions see the pin high while probing
		if ($urandom_range(4) == 0) begin
			run = $urandom_range(1, 3);
			for (i = 0; i < run; i++)
				queue_item(CMD_TICK, 1'b1);
		end
		lvl = 1'b0;
		run = lead;
		for (i = 0; i < n_ticks; i++) begin
			r = $urandom_range(99);
			if (r < 2)
				queue_item(CMD_MIC_ON, 1'($urandom_range(1)));
			else if (r < 4)
				queue_item(CMD_MIC_OFF, 1'($urandom_range(1)));
			else if (r == 4)
				queue_item(CMD_SW_ENABLE, 1'($urandom_range(1)));
			else if (r == 5) begin
				queue_item(CMD_SW_DISABLE, 1'($urandom_range(1)));
				queue_item(CMD_SW_ENABLE, 1'($urandom_range(1)));
			end else if (r == 6)
				queue_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
					1'($urandom_range(1)));
			else begin
				queue_item(CMD_TICK, lvl);
				run--;
				if (run <= 0) begin
					lvl = !lvl;
					run = $urandom_range(1, span);
				end
			end
		end
		if ($urandom_range(3) != 0)
			queue_item(CMD_SW_DISABLE, 1'($urandom_range(1)));
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || cmd_valid || predicted_rsp.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// stimulus and phase sequencing
	initial begin
		int k, target;
		cfg.settle_ticks = SETTLE_RST;
		cfg.poll_ticks = POLL_RST;
		cfg.retry_ticks = RETRY_RST;
		cfg.probe_attempts = ATTEMPTS_RST;
		cfg.probe_samples = SAMPLES_RST;
		cfg.release_samples = RELEASE_RST;
		ph = PH_IDLE;
		attempts_done = '0;
		samples = '0;
		wait_cnt = '0;
		{last_lvl, key_down, sw_req, tx_req, pull_on} = '0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_check();

		// all-zero registers, plus writes to unused slots that must be dropped
		send_idle_pct = 11;
		recv_idle_pct = 67;
		apply_settings(0, 0, 0, 0, 0, 0);
		cfg_write(SPARE_REG_A, 32'hffff_ffff);
		cfg_write(SPARE_REG_B, 32'h0000_0155);
		cfg_check();
		@(posedge clk);

		// directed: unknown codes, idle tick, mic, repeated commands, give-up
		queue_item(CMD_UNUSED_LO, 1'b1);
		queue_item(CMD_UNUSED_MID, 1'b0);
		queue_item(CMD_UNUSED_HI, 1'b1);
		queue_item(CMD_TICK, 1'b1);
		queue_item(CMD_MIC_ON, 1'b0);
		queue_item(CMD_MIC_OFF, 1'b1);
		queue_item(CMD_SW_DISABLE, 1'b0);
		queue_item(CMD_SW_ENABLE, 1'b0);
		queue_item(CMD_SW_ENABLE, 1'b1);
		queue_item(CMD_TICK, 1'b1);
		queue_item(CMD_TICK, 1'b0);
		queue_item(CMD_SW_DISABLE, 1'b1);
		// directed: press, aborted confirm, release, release by disable
		queue_item(CMD_SW_ENABLE, 1'b0);
		queue_item(CMD_TICK, 1'b0);
		queue_item(CMD_TICK, 1'b1);
		queue_item(CMD_TICK, 1'b0);
		queue_item(CMD_TICK, 1'b1);
		queue_item(CMD_TICK, 1'b0);
		queue_item(CMD_TICK, 1'b0);
		queue_item(CMD_TICK, 1'b1);
		queue_item(CMD_MIC_ON, 1'b1);
		queue_item(CMD_SW_DISABLE, 1'b0);
		queue_item(CMD_MIC_OFF, 1'b0);
		wait_drained();

		// random phases, each under its own register setting
		for (k = 0; k < 6; k++) begin
			if (k < 2) begin
				send_idle_pct = 11;
				recv_idle_pct = 67;
			end else if (k < 4) begin
				send_idle_pct = 67;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			target = 170;
			if (k == 0)
				apply_settings(1, 1, 1, 1, 1, 1);
			else if (k == 4) begin
				apply_settings(1023, 1023, 4095, 7, 7, 15);
				target = 85;
			end else
				apply_settings($urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 8), $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom_range(0, 15));
			@(posedge clk);
			target = queued + target;
			while (queued < target)
				queue_session($urandom_range(20, 80));
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("%0d items accepted and %0d results checked under %0d register settings",
			items_taken, rsp_seen, settings_run);
		$display("%0d key presses and %0d key releases predicted", presses, releases);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d failures", errors);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("run limit reached with %0d results outstanding", predicted_rsp.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
